// ----- rtl/dosw_pkg.sv -----
// shared widths, types and region codes for the tetrahedron dos weight unit
package dosw_pkg;

  localparam int FREQ_BITS        = 32;
  localparam int WEIGHT_FRAC_BITS = 32;
  localparam int WEIGHT_BITS      = 48;

  localparam int F_W    = FREQ_BITS;
  localparam int P2_W   = 2 * FREQ_BITS;
  localparam int P3_W   = 3 * FREQ_BITS;
  localparam int DEN_W  = 4 * FREQ_BITS;
  localparam int NUM_W  = 3 * FREQ_BITS + 4;
  localparam int SAT_SH = WEIGHT_BITS - WEIGHT_FRAC_BITS;
  localparam int CMP_W  = DEN_W + SAT_SH;
  localparam int DIV_STAGES = WEIGHT_BITS;

  typedef enum logic [1:0] {
    REG_ZERO,
    REG_RISE,
    REG_MID,
    REG_FALL
  } dosw_region_e;

  typedef struct packed {
    logic oerr;
    logic zero;
    logic sat;
  } dosw_side_t;

  typedef struct packed {
    logic [DEN_W-1:0]       r;
    logic [DEN_W-1:0]       d;
    logic [WEIGHT_BITS-1:0] feed;
    logic [WEIGHT_BITS-1:0] q;
    dosw_side_t             side;
  } dosw_div_t;

endpackage

// ----- rtl/dosw_front.sv -----
// region select, product pipeline and numerator/denominator forming
module dosw_front import dosw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [F_W-1:0]   edge_0_i,
  input  logic [F_W-1:0]   edge_1_i,
  input  logic [F_W-1:0]   edge_2_i,
  input  logic [F_W-1:0]   edge_3_i,
  input  logic [F_W-1:0]   probe_freq_i,
  output logic             valid_o,
  output dosw_div_t        div_o
);

  // stage 1: order check, region, differences
  logic             v1_q;
  logic             oerr1_q;
  dosw_region_e     reg1_q;
  logic [F_W-1:0]   t1_q, a1_q, b1_q, c1_q, e1_q, f1_q;
  logic             oerr1_d;
  dosw_region_e     reg1_d;
  logic [F_W-1:0]   t1_d, a1_d, b1_d, c1_d;
  logic [F_W-1:0]   d10, d20, d30, d21, d31, d32;

  assign d10 = edge_1_i - edge_0_i;
  assign d20 = edge_2_i - edge_0_i;
  assign d30 = edge_3_i - edge_0_i;
  assign d21 = edge_2_i - edge_1_i;
  assign d31 = edge_3_i - edge_1_i;
  assign d32 = edge_3_i - edge_2_i;

  always_comb begin
    oerr1_d = !((edge_0_i <= edge_1_i) && (edge_1_i <= edge_2_i) && (edge_2_i <= edge_3_i));
    t1_d = '0;
    a1_d = '0;
    b1_d = '0;
    c1_d = '0;
    priority if (oerr1_d) begin
      reg1_d = REG_ZERO;
    end else if (probe_freq_i <= edge_0_i) begin
      reg1_d = REG_ZERO;
    end else if (probe_freq_i <= edge_1_i) begin
      reg1_d = REG_RISE;
      t1_d = probe_freq_i - edge_0_i;
      a1_d = d10;
      b1_d = d20;
      c1_d = d30;
    end else if (probe_freq_i <= edge_2_i) begin
      reg1_d = REG_MID;
      t1_d = probe_freq_i - edge_1_i;
      a1_d = d21;
      b1_d = d31;
      c1_d = d10;
    end else if (probe_freq_i < edge_3_i) begin
      reg1_d = REG_FALL;
      t1_d = edge_3_i - probe_freq_i;
      a1_d = d30;
      b1_d = d31;
      c1_d = d32;
    end else begin
      reg1_d = REG_ZERO;
    end
  end

  // stage 2: first products
  logic              v2_q;
  logic              oerr2_q;
  dosw_region_e      reg2_q;
  logic [P2_W-1:0]   tt2_q, ab2_q, ef2_q;
  logic [F_W-1:0]    t2_q, c2_q;
  logic [F_W:0]      sum2_q;

  // stage 3: partial products, 32 by 33 at most
  logic              v3_q;
  logic              oerr3_q;
  dosw_region_e      reg3_q;
  logic [P2_W-1:0]   pc_lo_q, pc_hi_q, pt_lo_q, pt_hi_q;
  logic [P2_W:0]     pq_lo_q, pq_hi_q;
  logic [P2_W-1:0]   pd_ll_q, pd_lh_q, pd_hl_q, pd_hh_q;
  logic [P2_W-1:0]   tt3_q;

  // stage 4: partial sums
  logic              v4_q;
  logic              oerr4_q;
  dosw_region_e      reg4_q;
  logic [P3_W-1:0]   abc4_q, abt4_q;
  logic [P3_W:0]     q4_q;
  logic [DEN_W-1:0]  den4_q;
  logic [P2_W-1:0]   tt4_q;

  // stage 5: numerator terms
  logic              v5_q;
  logic              oerr5_q;
  dosw_region_e      reg5_q;
  logic [NUM_W-1:0]  p5_q, q5_q;
  logic [DEN_W-1:0]  den5_q;

  // stage 6: middle subtraction
  logic              v6_q;
  logic              oerr6_q, zero6_q;
  logic [NUM_W-1:0]  num6_q;
  logic [DEN_W-1:0]  den6_q;

  // stage 7: saturation test and divider setup
  logic              v7_q;
  dosw_div_t         div7_q;
  dosw_div_t         div7_d;
  logic [CMP_W-1:0]  num_sh, den_sh;

  logic [NUM_W-1:0]  p5_mid, p5_d, q5_d;
  logic [DEN_W-1:0]  den5_d;

  always_comb begin
    p5_mid = NUM_W'(abc4_q) + NUM_W'({abc4_q, 1'b0})
           + NUM_W'({abt4_q, 1'b0}) + NUM_W'({abt4_q, 2'b00});
    q5_d   = NUM_W'(q4_q) + NUM_W'({q4_q, 1'b0});
    if (reg4_q == REG_MID) begin
      p5_d   = p5_mid;
      den5_d = den4_q;
    end else begin
      p5_d   = NUM_W'({2'b00, tt4_q}) + NUM_W'({tt4_q, 1'b0});
      den5_d = DEN_W'(abc4_q);
    end
  end

  // quotient reaches 2^WEIGHT_BITS when num >= den * 2^(WEIGHT_BITS - WEIGHT_FRAC_BITS)
  always_comb begin
    num_sh = CMP_W'(num6_q);
    den_sh = CMP_W'({den6_q, {SAT_SH{1'b0}}});
    div7_d.r         = DEN_W'(num6_q[NUM_W-1:SAT_SH]);
    div7_d.d         = den6_q;
    div7_d.feed      = {num6_q[SAT_SH-1:0], {WEIGHT_FRAC_BITS{1'b0}}};
    div7_d.q         = '0;
    div7_d.side.oerr = oerr6_q;
    div7_d.side.zero = zero6_q;
    div7_d.side.sat  = !zero6_q && !oerr6_q && (num_sh >= den_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oerr1_q <= oerr1_d;
      reg1_q  <= reg1_d;
      t1_q    <= t1_d;
      a1_q    <= a1_d;
      b1_q    <= b1_d;
      c1_q    <= c1_d;
      e1_q    <= d20;
      f1_q    <= d30;

      oerr2_q <= oerr1_q;
      reg2_q  <= reg1_q;
      tt2_q   <= t1_q * t1_q;
      ab2_q   <= a1_q * b1_q;
      ef2_q   <= e1_q * f1_q;
      t2_q    <= t1_q;
      c2_q    <= c1_q;
      // d20 + d31 for the middle region
      sum2_q  <= {1'b0, e1_q} + {1'b0, b1_q};

      oerr3_q <= oerr2_q;
      reg3_q  <= reg2_q;
      pc_lo_q <= ab2_q[F_W-1:0] * c2_q;
      pc_hi_q <= ab2_q[P2_W-1:F_W] * c2_q;
      pt_lo_q <= ab2_q[F_W-1:0] * t2_q;
      pt_hi_q <= ab2_q[P2_W-1:F_W] * t2_q;
      pq_lo_q <= tt2_q[F_W-1:0] * sum2_q;
      pq_hi_q <= tt2_q[P2_W-1:F_W] * sum2_q;
      pd_ll_q <= ab2_q[F_W-1:0] * ef2_q[F_W-1:0];
      pd_lh_q <= ab2_q[F_W-1:0] * ef2_q[P2_W-1:F_W];
      pd_hl_q <= ab2_q[P2_W-1:F_W] * ef2_q[F_W-1:0];
      pd_hh_q <= ab2_q[P2_W-1:F_W] * ef2_q[P2_W-1:F_W];
      tt3_q   <= tt2_q;

      oerr4_q <= oerr3_q;
      reg4_q  <= reg3_q;
      abc4_q  <= P3_W'(pc_lo_q) + P3_W'({pc_hi_q, {F_W{1'b0}}});
      abt4_q  <= P3_W'(pt_lo_q) + P3_W'({pt_hi_q, {F_W{1'b0}}});
      q4_q    <= (P3_W + 1)'(pq_lo_q) + (P3_W + 1)'({pq_hi_q, {F_W{1'b0}}});
      den4_q  <= DEN_W'(pd_ll_q) + DEN_W'({pd_lh_q, {F_W{1'b0}}})
               + DEN_W'({pd_hl_q, {F_W{1'b0}}}) + {pd_hh_q, {P2_W{1'b0}}};
      tt4_q   <= tt3_q;

      oerr5_q <= oerr4_q;
      reg5_q  <= reg4_q;
      p5_q    <= p5_d;
      q5_q    <= q5_d;
      den5_q  <= den5_d;

      oerr6_q <= oerr5_q;
      if (reg5_q == REG_MID) begin
        zero6_q <= !(q5_q < p5_q);
        num6_q  <= p5_q - q5_q;
      end else begin
        zero6_q <= (reg5_q == REG_ZERO);
        num6_q  <= p5_q;
      end
      den6_q  <= den5_q;

      div7_q  <= div7_d;
    end
  end

  assign valid_o = v7_q;
  assign div_o   = div7_q;

endmodule

// ----- rtl/dosw_div_step.sv -----
// one restoring division step: one quotient bit per register stage
module dosw_div_step import dosw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  dosw_div_t div_i,
  output logic      valid_o,
  output dosw_div_t div_o
);

  logic             valid_q;
  dosw_div_t        div_q;
  dosw_div_t        div_d;
  logic [DEN_W:0]   rs;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    rs   = {div_i.r, div_i.feed[WEIGHT_BITS-1]};
    diff = rs - {1'b0, div_i.d};
    ge   = (rs >= {1'b0, div_i.d});
    div_d      = div_i;
    div_d.r    = ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
    div_d.feed = {div_i.feed[WEIGHT_BITS-2:0], 1'b0};
    div_d.q    = {div_i.q[WEIGHT_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ----- rtl/tetrahedron_dos_weight_unit.sv -----
// top level: linear-tetrahedron dos weight, front pipeline, pipelined restoring divider, output register
//
//   channel  direction  handshake                 payload
//   in       into unit  in_valid_i / in_stall_o   edge_0_i..edge_3_i, probe_freq_i
//   out      from unit  out_valid_o / out_stall_i weight_o, saturated_o, order_error_o
//
// one request per cycle while the output is not stalled
// the path is 7 product/forming stages, 48 divider stages (one quotient bit each), 1 output stage
// reset clears all valid bits; payload registers are not reset
// a stalled result freezes the whole pipeline, so nothing is dropped or repeated
module tetrahedron_dos_weight_unit import dosw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [F_W-1:0]         edge_0_i,
  input  logic [F_W-1:0]         edge_1_i,
  input  logic [F_W-1:0]         edge_2_i,
  input  logic [F_W-1:0]         edge_3_i,
  input  logic [F_W-1:0]         probe_freq_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WEIGHT_BITS-1:0] weight_o,
  output logic                   saturated_o,
  output logic                   order_error_o
);

  logic                   en;
  logic                   sv [DIV_STAGES+1];
  dosw_div_t              sd [DIV_STAGES+1];
  logic                   out_valid_q;
  logic [WEIGHT_BITS-1:0] weight_q, weight_d;
  logic                   sat_q, oerr_q;
  dosw_div_t              last;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign en         = !in_stall_o;

  dosw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .edge_0_i     (edge_0_i),
    .edge_1_i     (edge_1_i),
    .edge_2_i     (edge_2_i),
    .edge_3_i     (edge_3_i),
    .probe_freq_i (probe_freq_i),
    .valid_o      (sv[0]),
    .div_o        (sd[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    dosw_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[g]),
      .div_i   (sd[g]),
      .valid_o (sv[g+1]),
      .div_o   (sd[g+1])
    );
  end

  assign last = sd[DIV_STAGES];

  always_comb begin
    priority if (last.side.oerr || last.side.zero) begin
      weight_d = '0;
    end else if (last.side.sat) begin
      weight_d = '1;
    end else begin
      weight_d = last.q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      weight_q <= weight_d;
      sat_q    <= last.side.sat;
      oerr_q   <= last.side.oerr;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign weight_o      = weight_q;
  assign saturated_o   = sat_q;
  assign order_error_o = oerr_q;

endmodule

// ----- verif/tb_tetrahedron_dos_weight_unit.sv -----
// testbench for the tetrahedron dos weight unit: directed and random requests against a predictor
module tb_tetrahedron_dos_weight_unit import dosw_pkg::*; ;

  typedef bit [255:0] wide_t;

  typedef struct {
    bit [WEIGHT_BITS-1:0] weight;
    bit                   sat;
    bit                   oerr;
  } dos_weight_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [F_W-1:0]         edge_0_i = '0;
  logic [F_W-1:0]         edge_1_i = '0;
  logic [F_W-1:0]         edge_2_i = '0;
  logic [F_W-1:0]         edge_3_i = '0;
  logic [F_W-1:0]         probe_freq_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [WEIGHT_BITS-1:0] weight_o;
  logic                   saturated_o;
  logic                   order_error_o;

  dos_weight_t pending_weights[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  tetrahedron_dos_weight_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  // floor(n * 2^frac / d), clipped to the weight width
  function automatic dos_weight_t scale_quotient(wide_t n, wide_t d);
    dos_weight_t r;
    wide_t quot;
    quot = (n << WEIGHT_FRAC_BITS) / d;
    r.oerr = 1'b0;
    if (quot > wide_t'({WEIGHT_BITS{1'b1}})) begin
      r.weight = '1;
      r.sat = 1'b1;
    end else begin
      r.weight = quot[WEIGHT_BITS-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic dos_weight_t predict_weight(bit [31:0] c0, bit [31:0] c1, bit [31:0] c2,
                                                 bit [31:0] c3, bit [31:0] w);
    dos_weight_t r;
    wide_t e0, e1, e2, e3, wv, s, d10, d20, d30, d21, d31, d32, base, p, q;
    e0 = c0; e1 = c1; e2 = c2; e3 = c3; wv = w;
    d10 = e1 - e0; d20 = e2 - e0; d30 = e3 - e0;
    d21 = e2 - e1; d31 = e3 - e1; d32 = e3 - e2;
    r.weight = '0; r.sat = 1'b0; r.oerr = 1'b0;
    if (!(e0 <= e1 && e1 <= e2 && e2 <= e3)) begin
      r.oerr = 1'b1;
    end else if (wv <= e0) begin
      r.weight = '0;
    end else if (wv <= e1) begin
      s = wv - e0;
      r = scale_quotient(3 * s * s, d10 * d20 * d30);
    end else if (wv <= e2) begin
      s = wv - e1;
      base = d21 * d31;
      p = 3 * d10 * base + 6 * s * base;
      q = 3 * s * s * (d20 + d31);
      // guard against a negative middle numerator
      if (q < p) r = scale_quotient(p - q, base * d20 * d30);
    end else if (wv < e3) begin
      s = e3 - wv;
      r = scale_quotient(3 * s * s, d30 * d31 * d32);
    end
    return r;
  endfunction

  task automatic send_request(bit [31:0] c0, bit [31:0] c1, bit [31:0] c2, bit [31:0] c3,
                              bit [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    edge_0_i <= c0; edge_1_i <= c1; edge_2_i <= c2; edge_3_i <= c3;
    probe_freq_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_weights = {pending_weights, predict_weight(c0, c1, c2, c3, w)};
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    bit [31:0] mx;
    mx = '1;
    send_request(10, 20, 30, 40, 0);
    send_request(10, 20, 30, 40, 10);
    send_request(10, 20, 30, 40, 15);
    send_request(10, 20, 30, 40, 20);
    send_request(10, 20, 30, 40, 25);
    send_request(10, 20, 30, 40, 30);
    send_request(10, 20, 30, 40, 35);
    send_request(10, 20, 30, 40, 40);
    send_request(10, 20, 30, 40, mx);
    send_request(0, 0, 0, mx, 1);
    send_request(0, mx, mx, mx, 1);
    send_request(0, mx, mx, mx, mx - 1);
    send_request(0, 0, mx, mx, 32'h8000_0000);
    send_request(5, 5, 5, 5, 5);
    send_request(5, 6, 6, 7, 6);
    send_request(5, 6, 7, 8, 6);
    send_request(5, 6, 7, 8, 7);
    send_request(mx, mx, mx, mx, mx);
    send_request(0, 0, 0, 0, 0);
    // unsorted corners
    send_request(2, 1, 3, 4, 2);
    send_request(1, 3, 2, 4, 2);
    send_request(1, 2, 4, 3, 2);
    send_request(mx, 0, mx, 0, mx);
    send_request(32'h5555_5555, 32'haaaa_aaaa, 32'hcccc_cccc, 32'hffff_fff0, 32'h9999_9999);
  endtask

  task automatic test_random(int unsigned count);
    bit [32:0] c[4];
    bit [31:0] w;
    bit [33:0] lo, hi;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        send_request($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        c[0] = $urandom >> $urandom_range(31);
        if ($urandom_range(3) == 0) c[0] = $urandom;
        for (int k = 1; k < 4; k++) begin
          c[k] = c[k-1] + (($urandom_range(7) == 0) ? 0 : ($urandom >> $urandom_range(31)));
          if (c[k] > 33'hffff_ffff) c[k] = 33'hffff_ffff;
        end
        if ($urandom_range(4) == 0) begin
          w = c[$urandom_range(3)][31:0] + $urandom_range(2) - 1;
        end else begin
          lo = (c[0] == 0) ? 0 : c[0] - 1;
          hi = c[3] + 1;
          w = 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
        end
        send_request(c[0][31:0], c[1][31:0], c[2][31:0], c[3][31:0], w);
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    dos_weight_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result weight=%h sat=%b oerr=%b",
                 $time, weight_o, saturated_o, order_error_o);
        error_count++;
      end else begin
        exp_w = pending_weights.pop_front();
        if (weight_o !== exp_w.weight || saturated_o !== exp_w.sat ||
            order_error_o !== exp_w.oerr) begin
          $display("%0t: mismatch expected weight=%h sat=%b oerr=%b actual weight=%h sat=%b oerr=%b",
                   $time, exp_w.weight, exp_w.sat, exp_w.oerr,
                   weight_o, saturated_o, order_error_o);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 38; recv_idle_pct = 66;
    test_random(280);
    send_idle_pct = 66; recv_idle_pct = 38;
    test_random(280);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(280);
    in_valid_i <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
